// ----- rtl/rcs_pkg.sv -----
// Package for the ROM image checksum: seeds, accumulator types and the word rotate.
`default_nettype none
package rcs_pkg;

  localparam int unsigned REGION_W = 19;

  localparam logic [31:0]       SEED32       = 32'hF8CA_4DDC;
  localparam logic [63:0]       SEED64       = 64'hF8CA_4DDC_F8CA_4DDC;
  localparam logic [REGION_W-1:0] REGION_RESET = 19'h4_0000;

  typedef struct packed {
    logic [63:0] sum_acc;
    logic [31:0] xor_acc;
    logic [31:0] rot_sum_acc;
    logic [31:0] select_acc;
    logic [31:0] mix_acc;
  } acc_t;

  // Everything the finishing stage needs from the last word of an image.
  typedef struct packed {
    logic [31:0]         first;
    logic [31:0]         rot_sum;
    logic [31:0]         rot_sel;
    logic [31:0]         mix;
    logic [REGION_W-1:0] missing;
    logic                overrun;
  } fin_t;

  function automatic acc_t seed_acc();
    acc_t a;
    a.sum_acc     = SEED64;
    a.xor_acc     = SEED32;
    a.rot_sum_acc = SEED32;
    a.select_acc  = SEED32;
    a.mix_acc     = SEED32;
    return a;
  endfunction

  // Rotate left by the word's own low five bits.
  function automatic logic [31:0] rotl_self(input logic [31:0] x);
    logic [63:0] dbl;
    dbl = {x, x} << x[4:0];
    return dbl[63:32];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rcs_step.sv -----
// Per-word accumulator update: add, xor, self rotate, compare-selected xor and mix.
`default_nettype none
module rcs_step (
  input  wire logic [31:0]  data_word,
  input  wire rcs_pkg::acc_t acc,
  output rcs_pkg::acc_t     acc_nxt
);

  logic [31:0] rot_word;
  logic [63:0] sum_new;
  logic [31:0] rot_sum_new;

  always_comb begin
    rot_word    = rcs_pkg::rotl_self(data_word);
    sum_new     = acc.sum_acc + {32'd0, data_word};
    rot_sum_new = acc.rot_sum_acc + rot_word;

    acc_nxt.sum_acc     = sum_new;
    acc_nxt.xor_acc     = acc.xor_acc ^ data_word;
    acc_nxt.rot_sum_acc = rot_sum_new;
    // The compare uses the old select value, the xor the new low sum.
    if (acc.select_acc < data_word) begin
      acc_nxt.select_acc = acc.select_acc ^ sum_new[31:0] ^ data_word;
    end else begin
      acc_nxt.select_acc = acc.select_acc ^ rot_word;
    end
    acc_nxt.mix_acc = acc.mix_acc + (rot_sum_new ^ data_word);
  end

endmodule
`default_nettype wire

// ----- rtl/rcs_finish.sv -----
// Finishing stage and result register: zero-padding product, final xors, output hold.
`default_nettype none
module rcs_finish (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fin_load,
  input  wire rcs_pkg::fin_t fin_in,
  output logic               fin_free,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        out_checksum_first,
  output logic [31:0]        out_checksum_second,
  output logic               out_overrun
);

  logic          fin_valid_r;
  rcs_pkg::fin_t fin_r;
  logic          out_valid_r;
  logic [31:0]   first_r;
  logic [31:0]   second_r;
  logic          overrun_r;
  logic          out_load;
  logic [31:0]   pad_prod;
  logic [31:0]   mix_padded;

  assign out_load = fin_valid_r && (!out_valid_r || out_ready);
  assign fin_free = !fin_valid_r || out_load;

  always_comb begin
    pad_prod   = fin_r.rot_sum * {13'd0, fin_r.missing};
    mix_padded = fin_r.mix + pad_prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_load) begin
        fin_valid_r <= 1'b1;
      end else if (out_load) begin
        fin_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_r <= fin_in;
    end
    if (out_load) begin
      first_r   <= fin_r.first;
      second_r  <= fin_r.rot_sel ^ mix_padded;
      overrun_r <= fin_r.overrun;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_checksum_first  = first_r;
  assign out_checksum_second = second_r;
  assign out_overrun         = overrun_r;

endmodule
`default_nettype wire

// ----- rtl/rom_image_checksum.sv -----
// Top level of the streaming ROM image checksum.
//
// Input channel: one 32-bit image word per beat (in_data_word), with
// in_last_word marking the final word of an image. A result beat on the
// output channel carries the two checksum words and an overrun flag.
// Words are taken at one per cycle while in_ready is high; the five accumulators and the word
// counter are updated in the cycle of the beat.
// When the last word is accepted, the image's totals move to a finishing
// register and the accumulators are reseeded at once, so the first word of
// the next image may follow whenever in_ready is high. The finishing stage
// multiplies the rotate sum by the number of missing words (zero padding up
// to cfg region_words) and feeds the result register, which raises out_valid
// once the totals have passed from the finishing register into it.
// A result waiting on a stalled receiver holds steady; one further image
// may complete into the finishing register behind it, after which in_ready
// falls until the receiver takes its beat.
// Reset (rst_n low, synchronous) reseeds all accumulators, clears the word
// count and overrun flag, sets region_words to 262144 and empties the stages.
// Configuration writes via cfg_wr_en take effect from the next word.
`default_nettype none
module rom_image_checksum (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [18:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_checksum_first,
  output logic [31:0]      out_checksum_second,
  output logic             out_overrun
);

  logic [rcs_pkg::REGION_W-1:0] region_r;
  logic [rcs_pkg::REGION_W-1:0] word_count_r;
  logic [rcs_pkg::REGION_W-1:0] word_count_nxt;
  logic [rcs_pkg::REGION_W-1:0] missing;
  logic                         overrun_r;
  logic                         overrun_nxt;
  rcs_pkg::acc_t                acc_r;
  rcs_pkg::acc_t                acc_step;
  rcs_pkg::acc_t                acc_nxt;
  rcs_pkg::fin_t                fin;
  logic                         take;
  logic                         accept;
  logic                         fin_load;
  logic                         fin_free;

  rcs_step u_step (
    .data_word (in_data_word),
    .acc       (acc_r),
    .acc_nxt   (acc_step)
  );

  assign in_ready = fin_free;
  assign accept   = in_valid && in_ready;
  assign take     = word_count_r < region_r;
  assign fin_load = accept && in_last_word;

  always_comb begin
    if (take) begin
      acc_nxt        = acc_step;
      word_count_nxt = word_count_r + 19'd1;
      overrun_nxt    = overrun_r;
    end else begin
      acc_nxt        = acc_r;
      word_count_nxt = word_count_r;
      overrun_nxt    = 1'b1;
    end
    missing = (word_count_nxt < region_r) ? (region_r - word_count_nxt) : '0;

    fin.first   = acc_nxt.sum_acc[63:32] ^ acc_nxt.sum_acc[31:0] ^ acc_nxt.xor_acc;
    fin.rot_sum = acc_nxt.rot_sum_acc;
    fin.rot_sel = acc_nxt.rot_sum_acc ^ acc_nxt.select_acc;
    fin.mix     = acc_nxt.mix_acc;
    fin.missing = missing;
    fin.overrun = overrun_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r     <= rcs_pkg::REGION_RESET;
      acc_r        <= rcs_pkg::seed_acc();
      word_count_r <= '0;
      overrun_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        region_r <= cfg_wr_data;
      end
      if (fin_load) begin
        acc_r        <= rcs_pkg::seed_acc();
        word_count_r <= '0;
        overrun_r    <= 1'b0;
      end else if (accept) begin
        acc_r        <= acc_nxt;
        word_count_r <= word_count_nxt;
        overrun_r    <= overrun_nxt;
      end
    end
  end

  rcs_finish u_finish (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fin_load            (fin_load),
    .fin_in              (fin),
    .fin_free            (fin_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_checksum_first  (out_checksum_first),
    .out_checksum_second (out_checksum_second),
    .out_overrun         (out_overrun)
  );

endmodule
`default_nettype wire

// ----- rtl/rcs_checker.sv -----
// Port-level checker for the ROM image checksum, bound to the top level.
`default_nettype none
module rcs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_checksum_first,
  input wire logic [31:0] out_checksum_second,
  input wire logic        out_overrun
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat offered straight after reset");

  // The block only refuses words when both internal stages hold results.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused while the result side is not stalled");

  // The input side is open in the first cycle after reset.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_checksum_first)
      && $stable(out_checksum_second) && $stable(out_overrun)))
    else $error("result beat changed while stalled");

endmodule

bind rom_image_checksum rcs_checker u_rcs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_checksum_first  (out_checksum_first),
  .out_checksum_second (out_checksum_second),
  .out_overrun         (out_overrun)
);
`default_nettype wire
